// File: sv/sgre_pkg.sv
// ---------------------------------------------------------------------------
// sgre_pkg
// Shared constants, types and the 6x8 font table for the glyph expander.
// ---------------------------------------------------------------------------
package sgre_pkg;

    localparam logic [7:0]  GLYPH_FIRST = 8'h20;
    localparam logic [7:0]  GLYPH_LAST  = 8'h7E;
    localparam logic [7:0]  GLYPH_SUBST = 8'h3F;
    localparam int          GLYPH_COLS  = 6;
    localparam int          GLYPH_ROWS  = 8;
    localparam logic [5:0]  CELL_LAST   = 6'd47;
    localparam logic [10:0] SCREEN_MAX  = 11'd1024;
    localparam logic [10:0] SCREEN_W_RST = 11'd320;
    localparam logic [10:0] SCREEN_H_RST = 11'd240;

    // configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    localparam int ROM_DEPTH = 95 * GLYPH_COLS;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    typedef struct packed {
        logic              en;
        logic [ROM_AW-1:0] addr;
    } rom_req_t;

    // six column bytes per glyph, bit 0 is the top row
    localparam logic [7:0] FONT_ROM [0:ROM_DEPTH-1] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00, 8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00,
        8'h00,8'h07,8'h00,8'h07,8'h00,8'h00, 8'h14,8'h7F,8'h14,8'h7F,8'h14,8'h00,
        8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h00, 8'h23,8'h13,8'h08,8'h64,8'h62,8'h00,
        8'h36,8'h49,8'h55,8'h22,8'h50,8'h00, 8'h00,8'h05,8'h03,8'h00,8'h00,8'h00,
        8'h00,8'h1C,8'h22,8'h41,8'h00,8'h00, 8'h00,8'h41,8'h22,8'h1C,8'h00,8'h00,
        8'h08,8'h2A,8'h1C,8'h2A,8'h08,8'h00, 8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00,
        8'h00,8'h50,8'h30,8'h00,8'h00,8'h00, 8'h08,8'h08,8'h08,8'h08,8'h08,8'h00,
        8'h00,8'h60,8'h60,8'h00,8'h00,8'h00, 8'h20,8'h10,8'h08,8'h04,8'h02,8'h00,
        8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00, 8'h00,8'h42,8'h7F,8'h40,8'h00,8'h00,
        8'h42,8'h61,8'h51,8'h49,8'h46,8'h00, 8'h21,8'h41,8'h45,8'h4B,8'h31,8'h00,
        8'h18,8'h14,8'h12,8'h7F,8'h10,8'h00, 8'h27,8'h45,8'h45,8'h45,8'h39,8'h00,
        8'h3C,8'h4A,8'h49,8'h49,8'h30,8'h00, 8'h01,8'h71,8'h09,8'h05,8'h03,8'h00,
        8'h36,8'h49,8'h49,8'h49,8'h36,8'h00, 8'h06,8'h49,8'h49,8'h29,8'h1E,8'h00,
        8'h00,8'h36,8'h36,8'h00,8'h00,8'h00, 8'h00,8'h56,8'h36,8'h00,8'h00,8'h00,
        8'h00,8'h08,8'h14,8'h22,8'h41,8'h00, 8'h14,8'h14,8'h14,8'h14,8'h14,8'h00,
        8'h41,8'h22,8'h14,8'h08,8'h00,8'h00, 8'h02,8'h01,8'h51,8'h09,8'h06,8'h00,
        8'h32,8'h49,8'h79,8'h41,8'h3E,8'h00, 8'h7E,8'h11,8'h11,8'h11,8'h7E,8'h00,
        8'h7F,8'h49,8'h49,8'h49,8'h36,8'h00, 8'h3E,8'h41,8'h41,8'h41,8'h22,8'h00,
        8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h00, 8'h7F,8'h49,8'h49,8'h49,8'h41,8'h00,
        8'h7F,8'h09,8'h09,8'h01,8'h01,8'h00, 8'h3E,8'h41,8'h41,8'h51,8'h32,8'h00,
        8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00, 8'h00,8'h41,8'h7F,8'h41,8'h00,8'h00,
        8'h20,8'h40,8'h41,8'h3F,8'h01,8'h00, 8'h7F,8'h08,8'h14,8'h22,8'h41,8'h00,
        8'h7F,8'h40,8'h40,8'h40,8'h40,8'h00, 8'h7F,8'h02,8'h04,8'h02,8'h7F,8'h00,
        8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h00, 8'h3E,8'h41,8'h41,8'h41,8'h3E,8'h00,
        8'h7F,8'h09,8'h09,8'h09,8'h06,8'h00, 8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h00,
        8'h7F,8'h09,8'h19,8'h29,8'h46,8'h00, 8'h46,8'h49,8'h49,8'h49,8'h31,8'h00,
        8'h01,8'h01,8'h7F,8'h01,8'h01,8'h00, 8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h00,
        8'h1F,8'h20,8'h40,8'h20,8'h1F,8'h00, 8'h7F,8'h20,8'h18,8'h20,8'h7F,8'h00,
        8'h63,8'h14,8'h08,8'h14,8'h63,8'h00, 8'h03,8'h04,8'h78,8'h04,8'h03,8'h00,
        8'h61,8'h51,8'h49,8'h45,8'h43,8'h00, 8'h00,8'h00,8'h7F,8'h41,8'h41,8'h00,
        8'h02,8'h04,8'h08,8'h10,8'h20,8'h00, 8'h41,8'h41,8'h7F,8'h00,8'h00,8'h00,
        8'h04,8'h02,8'h01,8'h02,8'h04,8'h00, 8'h40,8'h40,8'h40,8'h40,8'h40,8'h00,
        8'h00,8'h01,8'h02,8'h04,8'h00,8'h00, 8'h20,8'h54,8'h54,8'h54,8'h78,8'h00,
        8'h7F,8'h48,8'h44,8'h44,8'h38,8'h00, 8'h38,8'h44,8'h44,8'h44,8'h20,8'h00,
        8'h38,8'h44,8'h44,8'h48,8'h7F,8'h00, 8'h38,8'h54,8'h54,8'h54,8'h18,8'h00,
        8'h08,8'h7E,8'h09,8'h01,8'h02,8'h00, 8'h08,8'h14,8'h54,8'h54,8'h3C,8'h00,
        8'h7F,8'h08,8'h04,8'h04,8'h78,8'h00, 8'h00,8'h44,8'h7D,8'h40,8'h00,8'h00,
        8'h20,8'h40,8'h44,8'h3D,8'h00,8'h00, 8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00,
        8'h00,8'h41,8'h7F,8'h40,8'h00,8'h00, 8'h7C,8'h04,8'h18,8'h04,8'h78,8'h00,
        8'h7C,8'h08,8'h04,8'h04,8'h78,8'h00, 8'h38,8'h44,8'h44,8'h44,8'h38,8'h00,
        8'h7C,8'h14,8'h14,8'h14,8'h08,8'h00, 8'h08,8'h14,8'h14,8'h18,8'h7C,8'h00,
        8'h7C,8'h08,8'h04,8'h04,8'h08,8'h00, 8'h48,8'h54,8'h54,8'h54,8'h20,8'h00,
        8'h04,8'h3F,8'h44,8'h40,8'h20,8'h00, 8'h3C,8'h40,8'h40,8'h20,8'h7C,8'h00,
        8'h1C,8'h20,8'h40,8'h20,8'h1C,8'h00, 8'h3C,8'h40,8'h30,8'h40,8'h3C,8'h00,
        8'h44,8'h28,8'h10,8'h28,8'h44,8'h00, 8'h0C,8'h50,8'h50,8'h50,8'h3C,8'h00,
        8'h44,8'h64,8'h54,8'h4C,8'h44,8'h00, 8'h00,8'h08,8'h36,8'h41,8'h00,8'h00,
        8'h00,8'h00,8'h7F,8'h00,8'h00,8'h00, 8'h00,8'h41,8'h36,8'h08,8'h00,8'h00,
        8'h08,8'h04,8'h08,8'h10,8'h08,8'h00
    };

endpackage

// File: sv/sgre_font_rom.sv
// ---------------------------------------------------------------------------
// sgre_font_rom
// Synchronous font ROM: one column byte per read, data registered and valid the cycle after the read.
// ---------------------------------------------------------------------------
module sgre_font_rom
    import sgre_pkg::*;
(
    input  logic       clk,
    input  rom_req_t   req,
    output logic [7:0] rdata
);

    logic [7:0] rdata_reg;

    // data holds when no read is issued
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            rdata_reg <= FONT_ROM[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/scaled_glyph_rect_expander.sv
// Flow: an accepted request waits in a one-entry buffer until the cell sequencer
// loads it; each cell then passes the font ROM read and the stage 1 registers, which
// run side by side, and then the output register, one cell a cycle while out_ready
// does not stall the output. The cell sequencer issues one font ROM column read per cell.
// Reset: async active low; clears control, cursor to 0, screen size 320x240.
// ---------------------------------------------------------------------------
// scaled_glyph_rect_expander
// Expands one character into 48 scaled, clipped cell rectangles.
// ---------------------------------------------------------------------------
module scaled_glyph_rect_expander
    import sgre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [7:0]  char_code,
    input  logic [15:0] fg_color,
    input  logic [15:0] bg_color,
    input  logic [7:0]  scale,
    input  logic        continue_line,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  rect_x,
    output logic [9:0]  rect_y,
    output logic [7:0]  rect_w,
    output logic [7:0]  rect_h,
    output logic [15:0] rect_color,
    output logic        visible,
    output logic        last
);

    // configuration, stored already clamped to the panel maximum
    logic [10:0] sw_reg;
    logic [10:0] sh_reg;
    logic [10:0] cfg_clamped;

    assign cfg_clamped = (cfg_data > SCREEN_MAX) ? SCREEN_MAX : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= SCREEN_W_RST;
            sh_reg <= SCREEN_H_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  sw_reg <= cfg_clamped;
                CFG_SCREEN_HEIGHT: sh_reg <= cfg_clamped;
            endcase
        end
    end

    // pipeline advance: output register empty or being drained
    logic adv;
    logic out_valid_reg;
    assign adv = !out_valid_reg || out_ready;

    // one-entry request buffer
    logic        pend_valid_reg;
    logic [15:0] pend_x_reg;
    logic [15:0] pend_y_reg;
    logic [7:0]  pend_code_reg;
    logic [15:0] pend_fg_reg;
    logic [15:0] pend_bg_reg;
    logic [7:0]  pend_scale_reg;
    logic        pend_cont_reg;

    // active character
    logic        act_valid_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] base_x_reg;
    logic [15:0] py_reg;
    logic [ROM_AW-1:0] glyph_base_reg;
    logic [15:0] fg_reg;
    logic [15:0] bg_reg;
    logic [7:0]  scale_reg;
    logic [15:0] cursor_reg;

    logic              load_act;
    logic              issue;
    logic              cell_last;
    logic [15:0]       base_x_next;
    logic [7:0]        scale_next;
    logic [7:0]        code_eff;
    logic [6:0]        glyph_idx;
    logic [ROM_AW-1:0] glyph_base_next;

    assign in_ready  = !pend_valid_reg;
    assign cell_last = (cnt_reg == CELL_LAST);
    assign issue     = adv && act_valid_reg;
    assign load_act  = pend_valid_reg && (!act_valid_reg || (issue && cell_last));

    assign base_x_next = pend_cont_reg ? cursor_reg : pend_x_reg;
    assign scale_next  = (pend_scale_reg == 8'd0) ? 8'd1 : pend_scale_reg;
    assign code_eff    = (pend_code_reg < GLYPH_FIRST || pend_code_reg > GLYPH_LAST)
                         ? GLYPH_SUBST : pend_code_reg;
    assign glyph_idx   = 7'(code_eff - GLYPH_FIRST);
    // idx * 6 as shift-add
    assign glyph_base_next = (ROM_AW'(glyph_idx) << 2) + (ROM_AW'(glyph_idx) << 1);

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pend_x_reg     <= pos_x;
            pend_y_reg     <= pos_y;
            pend_code_reg  <= char_code;
            pend_fg_reg    <= fg_color;
            pend_bg_reg    <= bg_color;
            pend_scale_reg <= scale;
            pend_cont_reg  <= continue_line;
        end
        if (load_act)
        begin
            base_x_reg     <= base_x_next;
            py_reg         <= pend_y_reg;
            glyph_base_reg <= glyph_base_next;
            fg_reg         <= pend_fg_reg;
            bg_reg         <= pend_bg_reg;
            scale_reg      <= scale_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            act_valid_reg  <= 1'b0;
            cnt_reg        <= 6'd0;
            cursor_reg     <= 16'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (load_act)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (load_act)
            begin
                act_valid_reg <= 1'b1;
                cnt_reg       <= 6'd0;
                cursor_reg    <= base_x_next + (16'(scale_next) << 2)
                                             + (16'(scale_next) << 1);
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cell_last)
                begin
                    act_valid_reg <= 1'b0;
                end
            end
        end
    end

    // cell issue: column-major, cnt = {col, row}
    logic [2:0]  col;
    logic [2:0]  row;
    rom_req_t    rom_req;
    logic [7:0]  rom_data;

    assign col          = cnt_reg[5:3];
    assign row          = cnt_reg[2:0];
    assign rom_req.en   = issue;
    assign rom_req.addr = glyph_base_reg + ROM_AW'(col);

    sgre_font_rom u_rom
    (
        .clk   (clk),
        .req   (rom_req),
        .rdata (rom_data)
    );

    // stage 1: cell origin, aligned with ROM data
    logic        s1_valid_reg;
    logic [15:0] s1_x_reg;
    logic [15:0] s1_y_reg;
    logic [2:0]  s1_row_reg;
    logic [15:0] s1_fg_reg;
    logic [15:0] s1_bg_reg;
    logic [7:0]  s1_scale_reg;
    logic        s1_last_reg;

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_x_reg     <= base_x_reg + 16'(11'(col) * 11'(scale_reg));
            s1_y_reg     <= py_reg + 16'(11'(row) * 11'(scale_reg));
            s1_row_reg   <= row;
            s1_fg_reg    <= fg_reg;
            s1_bg_reg    <= bg_reg;
            s1_scale_reg <= scale_reg;
            s1_last_reg  <= cell_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue;
        end
    end

    // stage 2: clip against the screen
    logic        x_on;
    logic        y_on;
    logic        vis_next;
    logic [16:0] x_end;
    logic [16:0] y_end;
    logic [7:0]  w_next;
    logic [7:0]  h_next;

    assign x_on     = s1_x_reg < 16'(sw_reg);
    assign y_on     = s1_y_reg < 16'(sh_reg);
    assign vis_next = x_on && y_on;
    assign x_end    = 17'(s1_x_reg) + 17'(s1_scale_reg);
    assign y_end    = 17'(s1_y_reg) + 17'(s1_scale_reg);
    assign w_next   = (x_end > 17'(sw_reg)) ? 8'(sw_reg - s1_x_reg[10:0]) : s1_scale_reg;
    assign h_next   = (y_end > 17'(sh_reg)) ? 8'(sh_reg - s1_y_reg[10:0]) : s1_scale_reg;

    logic [9:0]  rect_x_reg;
    logic [9:0]  rect_y_reg;
    logic [7:0]  rect_w_reg;
    logic [7:0]  rect_h_reg;
    logic [15:0] rect_color_reg;
    logic        visible_reg;
    logic        last_reg;

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            rect_x_reg     <= vis_next ? s1_x_reg[9:0] : 10'd0;
            rect_y_reg     <= vis_next ? s1_y_reg[9:0] : 10'd0;
            rect_w_reg     <= vis_next ? w_next : 8'd0;
            rect_h_reg     <= vis_next ? h_next : 8'd0;
            rect_color_reg <= rom_data[s1_row_reg] ? s1_fg_reg : s1_bg_reg;
            visible_reg    <= vis_next;
            last_reg       <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign rect_x     = rect_x_reg;
    assign rect_y     = rect_y_reg;
    assign rect_w     = rect_w_reg;
    assign rect_h     = rect_h_reg;
    assign rect_color = rect_color_reg;
    assign visible    = visible_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_invis_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !visible_reg |-> rect_w_reg == 8'd0 && rect_h_reg == 8'd0)
        else $error("invisible cell with nonzero size");

    a_vis_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && visible_reg |-> rect_w_reg != 8'd0 && rect_h_reg != 8'd0)
        else $error("visible cell with zero size");

    a_scale_nz: assert property (@(posedge clk) disable iff (!rst_n)
        act_valid_reg |-> scale_reg != 8'd0)
        else $error("active character with zero scale");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        issue && cell_last && !pend_valid_reg |=> !act_valid_reg)
        else $error("sequencer ran past the last cell");
`endif

endmodule

// File: sim/sgre_cell_checker.sv
// ---------------------------------------------------------------------------
// sgre_cell_checker
// Watches the glyph expander's request, config and cell channels, predicts
// the 48 cells of every accepted character and compares each cell returned.
// ---------------------------------------------------------------------------
module sgre_cell_checker
    import sgre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,

    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [7:0]  char_code,
    input  logic [15:0] fg_color,
    input  logic [15:0] bg_color,
    input  logic [7:0]  scale,
    input  logic        continue_line,

    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [9:0]  rect_x,
    input  logic [9:0]  rect_y,
    input  logic [7:0]  rect_w,
    input  logic [7:0]  rect_h,
    input  logic [15:0] rect_color,
    input  logic        visible,
    input  logic        last,

    output int          fail_count,
    output int          pending,
    output int          cells_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [7:0]  w;
        logic [7:0]  h;
        logic [15:0] color;
        logic        vis;
        logic        is_last;
    } cell_t;

    cell_t       cell_queue[$];
    cell_t       want;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [15:0] cursor_col;

    initial
    begin
        fail_count    = 0;
        pending       = 0;
        cells_checked = 0;
    end

    function automatic int screen_dim(logic [10:0] v);
        return (v > SCREEN_MAX) ? int'(SCREEN_MAX) : int'(v);
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] %s", $time, msg);
    endtask

    // builds the cells of the request on the input ports right now
    task automatic expand_glyph();
        int          sc;
        int          sw;
        int          sh;
        int          base;
        int          x;
        int          y;
        int          w;
        int          h;
        logic [7:0]  code;
        logic [7:0]  bits;
        cell_t       c;

        sc   = (scale == 8'd0) ? 1 : int'(scale);
        code = (char_code < GLYPH_FIRST || char_code > GLYPH_LAST) ? GLYPH_SUBST : char_code;
        sw   = screen_dim(width_reg);
        sh   = screen_dim(height_reg);
        base = continue_line ? int'(cursor_col) : int'(pos_x);

        for (int col = 0; col < GLYPH_COLS; col++)
        begin
            bits = FONT_ROM[(int'(code) - int'(GLYPH_FIRST)) * GLYPH_COLS + col];
            for (int row = 0; row < GLYPH_ROWS; row++)
            begin
                x = (base + col * sc) & 'hFFFF;
                y = (int'(pos_y) + row * sc) & 'hFFFF;
                c.color = bits[row] ? fg_color : bg_color;
                if (x < sw && y < sh)
                begin
                    w = sc;
                    h = sc;
                    if (x + w > sw)
                        w = sw - x;
                    if (y + h > sh)
                        h = sh - y;
                    c.x   = x[9:0];
                    c.y   = y[9:0];
                    c.w   = w[7:0];
                    c.h   = h[7:0];
                    c.vis = 1'b1;
                end
                else
                begin
                    c.x   = '0;
                    c.y   = '0;
                    c.w   = '0;
                    c.h   = '0;
                    c.vis = 1'b0;
                end
                c.is_last = (col == GLYPH_COLS - 1) && (row == GLYPH_ROWS - 1);
                cell_queue.push_back(c);
            end
        end
        cursor_col = 16'((base + GLYPH_COLS * sc) & 'hFFFF);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_queue.delete();
            width_reg  = SCREEN_W_RST;
            height_reg = SCREEN_H_RST;
            cursor_col = '0;
            pending    = 0;
        end
        else
        begin
            // results first: a cell leaving now never belongs to a request taken now
            if (out_valid && out_ready)
            begin
                if (cell_queue.size() == 0)
                    report_mismatch($sformatf("cell %0d arrived with nothing expected",
                                              cells_checked));
                else
                begin
                    want = cell_queue.pop_front();
                    if (rect_x !== want.x)
                        report_mismatch($sformatf("cell %0d rect_x 0x%0h, expected 0x%0h",
                                                  cells_checked, rect_x, want.x));
                    if (rect_y !== want.y)
                        report_mismatch($sformatf("cell %0d rect_y 0x%0h, expected 0x%0h",
                                                  cells_checked, rect_y, want.y));
                    if (rect_w !== want.w)
                        report_mismatch($sformatf("cell %0d rect_w 0x%0h, expected 0x%0h",
                                                  cells_checked, rect_w, want.w));
                    if (rect_h !== want.h)
                        report_mismatch($sformatf("cell %0d rect_h 0x%0h, expected 0x%0h",
                                                  cells_checked, rect_h, want.h));
                    if (rect_color !== want.color)
                        report_mismatch($sformatf("cell %0d rect_color 0x%0h, expected 0x%0h",
                                                  cells_checked, rect_color, want.color));
                    if (visible !== want.vis)
                        report_mismatch($sformatf("cell %0d visible %b, expected %b",
                                                  cells_checked, visible, want.vis));
                    if (last !== want.is_last)
                        report_mismatch($sformatf("cell %0d last %b, expected %b",
                                                  cells_checked, last, want.is_last));
                end
                cells_checked++;
            end

            if (cfg_we)
            begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
            end

            if (in_valid && in_ready)
                expand_glyph();

            pending = cell_queue.size();
        end
    end

endmodule

// File: sim/tb_scaled_glyph_rect_expander.sv
// ---------------------------------------------------------------------------
// tb_scaled_glyph_rect_expander
// Drives characters through the glyph expander under a series of screen
// sizes: a directed set of corner requests, then random strings of text,
// with bursty requests and a stalling cell receiver. A separate checker
// predicts and compares every cell.
// ---------------------------------------------------------------------------
module tb_scaled_glyph_rect_expander;
    timeunit 1ns;
    timeprecision 1ps;
    import sgre_pkg::*;

    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic [7:0]  code;
        logic [7:0]  scl;
        logic        cont;
        logic [15:0] fg;
        logic [15:0] bg;
    } glyph_req_t;

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_STALLS} rx_mode_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = CFG_SCREEN_WIDTH;
    logic [10:0] cfg_data      = '0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic [15:0] pos_x         = '0;
    logic [15:0] pos_y         = '0;
    logic [7:0]  char_code     = '0;
    logic [15:0] fg_color      = '0;
    logic [15:0] bg_color      = '0;
    logic [7:0]  scale         = '0;
    logic        continue_line = 1'b0;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [9:0]  rect_x;
    logic [9:0]  rect_y;
    logic [7:0]  rect_w;
    logic [7:0]  rect_h;
    logic [15:0] rect_color;
    logic        visible;
    logic        last;

    int fail_count;
    int pending;
    int cells_checked;

    int chars_sent    = 0;
    int settings_used = 0;
    int burst_left    = 0;
    int cur_w         = 320;
    int cur_h         = 240;

    rx_mode_t rx_mode    = RX_ALWAYS;
    int       mode_left  = 0;
    int       stall_left = 0;

    scaled_glyph_rect_expander i_dut (.*);

    sgre_cell_checker i_checker (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: switches between stall patterns, picking a new one when its mode count runs out
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            rx_mode    = rx_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 300);
            stall_left = 0;
        end
        else
            mode_left--;
        case (rx_mode)
            RX_ALWAYS: out_ready <= 1'b1;
            RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_ready <= 1'b0;
                end
                else
                begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0)
                        stall_left = $urandom_range(1, 20);
                end
            end
        endcase
    end

    function automatic glyph_req_t mk_glyph(int px, int py, int code, int scl, bit cont,
                                            int fg, int bg);
        glyph_req_t r;
        r.px   = px[15:0];
        r.py   = py[15:0];
        r.code = code[7:0];
        r.scl  = scl[7:0];
        r.cont = cont;
        r.fg   = fg[15:0];
        r.bg   = bg[15:0];
        return r;
    endfunction

    // mostly on-screen text with small scales, some wrap-around and raw noise
    function automatic glyph_req_t rand_glyph();
        glyph_req_t r;
        int         ew;
        int         eh;
        int         sel;

        ew = (cur_w > 1024) ? 1024 : cur_w;
        eh = (cur_h > 1024) ? 1024 : cur_h;
        r.code = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(32, 126))
                                            : 8'($urandom_range(0, 255));
        r.fg = 16'($urandom);
        r.bg = 16'($urandom);
        sel = $urandom_range(0, 9);
        if (sel < 6)
            r.scl = 8'($urandom_range(1, 4));
        else if (sel < 8)
            r.scl = 8'($urandom_range(5, 32));
        else if (sel == 8)
            r.scl = 8'd0;
        else
            r.scl = 8'($urandom_range(33, 255));
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            r.px = 16'($urandom_range(0, ew + 16));
            r.py = 16'($urandom_range(0, eh + 16));
        end
        else if (sel == 7)
        begin
            r.px = 16'hFFFF - 16'($urandom_range(0, 300));
            r.py = 16'hFFFF - 16'($urandom_range(0, 300));
        end
        else
        begin
            r.px = 16'($urandom);
            r.py = 16'($urandom);
        end
        r.cont = ($urandom_range(0, 9) < 4);
        return r;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 11))
            0:       return 0;
            1:       return 1;
            2:       return 2;
            3:       return 7;
            4:       return 240;
            5:       return 320;
            6:       return 640;
            7:       return 1023;
            8:       return 1024;
            9:       return 1025;
            10:      return 2047;
            default: return $urandom_range(0, 2047);
        endcase
    endfunction

    // requests go out in bursts; every burst starts after a random gap with in_valid low
    task automatic send_glyph(glyph_req_t r);
        int gap;

        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        pos_x         <= r.px;
        pos_y         <= r.py;
        char_code     <= r.code;
        fg_color      <= r.fg;
        bg_color      <= r.bg;
        scale         <= r.scl;
        continue_line <= r.cont;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        chars_sent++;
        burst_left--;
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    // hold off requests until every expected cell is back
    task automatic drain();
        if (burst_left != 0)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
        end
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_screen(int w, int h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= w[10:0];
        @(posedge clk);
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= h[10:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        cur_w = w;
        cur_h = h;
        settings_used++;
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset screen size 320x240
        settings_used = 1;
        send_glyph(mk_glyph(0, 0, 8'h41, 1, 1'b0, 16'hFFFF, 16'h0000));
        send_glyph(mk_glyph(10, 10, 8'h00, 0, 1'b0, 16'hF800, 16'h07E0));   // unprintable, scale 0
        send_glyph(mk_glyph(0, 20, 8'hFF, 2, 1'b1, 16'h001F, 16'hFFE0));
        send_glyph(mk_glyph(0, 20, 8'h1F, 1, 1'b1, 16'h1234, 16'h5678));
        send_glyph(mk_glyph(0, 20, 8'h7F, 1, 1'b1, 16'hAAAA, 16'h5555));
        send_glyph(mk_glyph(100, 50, 8'h20, 3, 1'b0, 16'hFFFF, 16'h0001));
        send_glyph(mk_glyph(0, 0, 8'h7E, 1, 1'b1, 16'h8000, 16'h7FFF));
        send_glyph(mk_glyph(315, 235, 8'h23, 4, 1'b0, 16'hFFFF, 16'h0000)); // edge overlap
        send_glyph(mk_glyph(16'hFFFF, 16'hFFFF, 8'h4D, 2, 1'b0, 16'h0F0F, 16'hF0F0)); // wrap
        send_glyph(mk_glyph(320, 0, 8'h58, 1, 1'b0, 16'hFFFF, 16'h0000));   // just off the edge
        send_glyph(mk_glyph(0, 0, 8'h40, 255, 1'b0, 16'h0000, 16'hFFFF));
        send_glyph(mk_glyph(16'hFFF0, 5, 8'h5A, 8, 1'b0, 16'hC3C3, 16'h3C3C));
        send_glyph(mk_glyph(0, 5, 8'h61, 8, 1'b1, 16'h3C3C, 16'hC3C3));      // cursor wraps
        drain();

        set_screen(1024, 1024);
        send_glyph(mk_glyph(900, 900, 8'h57, 255, 1'b0, 16'hFFFF, 16'h0000));
        send_glyph(mk_glyph(1023, 1023, 8'h2A, 1, 1'b0, 16'h1111, 16'hEEEE));
        drain();

        set_screen(2047, 1100);                                              // oversized
        send_glyph(mk_glyph(1000, 1020, 8'h26, 16, 1'b0, 16'hBEEF, 16'h4110));
        drain();

        set_screen(0, 5);                                                    // zero width
        send_glyph(mk_glyph(0, 0, 8'h42, 1, 1'b0, 16'hFFFF, 16'h0000));
        drain();

        set_screen(1, 1);
        send_glyph(mk_glyph(0, 0, 8'h7C, 3, 1'b0, 16'hFFFF, 16'h0000));
        send_glyph(mk_glyph(0, 0, 8'h30, 1, 1'b0, 16'h0001, 16'h8000));
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                set_screen(320, 240);
            else
                set_screen(pick_dim(), pick_dim());
            for (int n = 0; n < 40; n++)
            begin
                if (n == 20 && phase % 2 == 1)
                    drain();
                send_glyph(rand_glyph());
            end
            drain();
        end

        $display("Sent %0d characters under %0d screen settings, %0d cells compared.",
                 chars_sent, settings_used, cells_checked);
        $display("Covered unprintable codes, zero and large scales, wrap-around, clipping, ",
                 "zero and oversized screens, line continuation.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/sgre_pkg.sv
sv/sgre_font_rom.sv
sv/scaled_glyph_rect_expander.sv
sim/sgre_cell_checker.sv
sim/tb_scaled_glyph_rect_expander.sv
